@@ src/gtes_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, constants and sequencer states of the greedy tour edge selector.
package gtes_pkg;

    localparam int VERTEX_W         = 6;
    localparam int WEIGHT_W         = 16;
    localparam int COUNT_W          = 7;
    localparam int LENGTH_W         = 22;
    localparam int DEGREE_W         = 2;
    localparam int MAX_VERTICES_DEF = 64;

    localparam logic [DEGREE_W-1:0] FULL_DEGREE  = 2'd2;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX   = 22'h3F_FFFF;
    localparam logic [COUNT_W-1:0]  VCOUNT_RESET = 7'd4;

    typedef logic [COUNT_W-1:0] vcount_t;

    typedef struct packed {
        logic                new_tour;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [VERTEX_W-1:0] end_a;
        logic [VERTEX_W-1:0] end_b;
    } edge_item_t;

    typedef struct packed {
        logic                accepted;
        logic [COUNT_W-1:0]  edges_taken;
        logic [LENGTH_W-1:0] tour_length;
        logic                tour_done;
    } result_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEG_A,
        S_DEG_B,
        S_DEG_CHK,
        S_WALK,
        S_DECIDE,
        S_DEG_UPD_B,
        S_RESULT
    } state_t;

endpackage

@@ src/gtes_stream_if.sv @@
`timescale 1ns / 1ps
// Interface: valid/ready channel carrying one item of a given payload type.
interface gtes_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/greedy_tour_edge_selector.sv @@
`timescale 1ns / 1ps
// Greedy edge tour builder with a union-find forest kept in RAM.
// The two root walks go through the parent-link RAM, one link per cycle.
// Throughput: one item at a time; the next item is taken once the result is in the
//   output register, which waits while the previous result is not yet taken.
// Reset: vertex_count = 4, empty forest, zero degrees, count and length.
module greedy_tour_edge_selector #(
    parameter int MAX_VERTICES = gtes_pkg::MAX_VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    gtes_stream_if.sink   edge_item,
    gtes_stream_if.source result,
    gtes_stream_if.sink   cfg
);
    import gtes_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int STEP_W = $clog2(MAX_VERTICES + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_VERTICES - 1);

    typedef logic [ADDR_W-1:0] vaddr_t;

    // ---------------- control state ----------------
    state_t                  state_reg, state_next;
    vcount_t                 vcount_reg, vcount_next;
    logic [COUNT_W-1:0]      taken_reg, taken_next;
    logic [LENGTH_W-1:0]     sum_reg, sum_next;
    logic [MAX_VERTICES-1:0] link_valid_reg, link_valid_next;   // entry written since clear
    logic [MAX_VERTICES-1:0] deg_valid_reg, deg_valid_next;
    logic                    out_valid_reg, out_valid_next;

    // ---------------- working payload ----------------
    vaddr_t                  a_reg, a_next;
    vaddr_t                  b_reg, b_next;
    logic [WEIGHT_W-1:0]     w_reg, w_next;
    logic [DEGREE_W-1:0]     deg_a_reg, deg_a_next;
    logic [DEGREE_W-1:0]     deg_b_reg, deg_b_next;
    vaddr_t                  walk_v_reg, walk_v_next;          // vertex whose link is being read
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    phase_b_reg, phase_b_next;        // 0: walking from a, 1: from b
    vaddr_t                  ra_reg, ra_next;
    vaddr_t                  rb_reg, rb_next;
    logic                    accepted_reg, accepted_next;
    logic                    link_rvalid_reg, link_rvalid_next; // valid bit of the pending read
    logic                    deg_rvalid_reg, deg_rvalid_next;
    result_item_t            out_data_reg, out_data_next;

    // ---------------- RAM ports ----------------
    logic                link_we;
    vaddr_t              link_waddr, link_raddr, link_rdata;
    logic                deg_we;
    vaddr_t              deg_waddr, deg_raddr;
    logic [DEGREE_W-1:0] deg_wdata, deg_rdata;

    gtes_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_VERTICES)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (ra_reg),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    gtes_ram #(
        .WIDTH (DEGREE_W),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // Entries never written since the last clear read as their reset value:
    // a link points to itself, a degree is zero.
    logic [DEGREE_W-1:0] deg_rd;
    vaddr_t              link_up;
    assign deg_rd  = deg_rvalid_reg  ? deg_rdata  : '0;
    assign link_up = link_rvalid_reg ? link_rdata : walk_v_reg;

    // Walk step decode: root found when the link points back, or the step bound is hit.
    logic   walk_found, walk_done;
    vaddr_t walk_root;
    assign walk_found = (link_up == walk_v_reg);
    assign walk_done  = walk_found || (step_reg == STEP_LAST);
    assign walk_root  = walk_found ? walk_v_reg : link_up;

    // Saturating length update.
    logic [LENGTH_W:0]   sum_ext;
    logic [LENGTH_W-1:0] sum_sat;
    assign sum_ext = {1'b0, sum_reg} + (LENGTH_W + 1)'(w_reg);
    assign sum_sat = (sum_ext > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : sum_ext[LENGTH_W-1:0];

    logic closing;
    assign closing = ((taken_reg + 7'd1) == vcount_reg);

    // Configuration: the register takes every write.
    assign cfg.ready = 1'b1;
    assign vcount_next = cfg.valid ? cfg.data : vcount_reg;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------- sequencer ----------------
    always_comb
    begin
        logic                  a_ok;
        logic                  b_ok;
        logic [COUNT_W-1:0]    taken_eff;

        state_next       = state_reg;
        taken_next       = taken_reg;
        sum_next         = sum_reg;
        link_valid_next  = link_valid_reg;
        deg_valid_next   = deg_valid_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        w_next           = w_reg;
        deg_a_next       = deg_a_reg;
        deg_b_next       = deg_b_reg;
        walk_v_next      = walk_v_reg;
        step_next        = step_reg;
        phase_b_next     = phase_b_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        accepted_next    = accepted_reg;
        link_rvalid_next = link_rvalid_reg;
        deg_rvalid_next  = deg_rvalid_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !result.ready;

        link_we    = 1'b0;
        link_waddr = rb_reg;
        link_raddr = walk_v_reg;
        deg_we     = 1'b0;
        deg_waddr  = a_reg;
        deg_wdata  = deg_a_reg + 2'd1;
        deg_raddr  = a_reg;

        edge_item.ready = 1'b0;

        a_ok      = (int'(edge_item.data.end_a) < MAX_VERTICES);
        b_ok      = (int'(edge_item.data.end_b) < MAX_VERTICES);
        taken_eff = edge_item.data.new_tour ? '0 : taken_reg;

        case (state_reg)
            S_IDLE:
            begin
                edge_item.ready = 1'b1;
                if (edge_item.valid)
                begin
                    if (edge_item.data.new_tour)
                    begin
                        link_valid_next = '0;
                        deg_valid_next  = '0;
                        taken_next      = '0;
                        sum_next        = '0;
                    end
                    a_next        = vaddr_t'(edge_item.data.end_a);
                    b_next        = vaddr_t'(edge_item.data.end_b);
                    w_next        = edge_item.data.edge_weight;
                    accepted_next = 1'b0;
                    if (a_ok && b_ok && (taken_eff < vcount_reg))
                    begin
                        state_next = S_DEG_A;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_DEG_A:
            begin
                deg_raddr       = a_reg;
                deg_rvalid_next = deg_valid_reg[a_reg];
                state_next      = S_DEG_B;
            end

            S_DEG_B:
            begin
                deg_a_next      = deg_rd;
                deg_raddr       = b_reg;
                deg_rvalid_next = deg_valid_reg[b_reg];
                state_next      = S_DEG_CHK;
            end

            S_DEG_CHK:
            begin
                deg_b_next = deg_rd;
                if ((deg_a_reg < FULL_DEGREE) && (deg_rd < FULL_DEGREE))
                begin
                    walk_v_next      = a_reg;
                    step_next        = '0;
                    phase_b_next     = 1'b0;
                    link_raddr       = a_reg;
                    link_rvalid_next = link_valid_reg[a_reg];
                    state_next       = S_WALK;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_WALK:
            begin
                if (!walk_done)
                begin
                    walk_v_next      = link_up;
                    step_next        = step_reg + 1'b1;
                    link_raddr       = link_up;
                    link_rvalid_next = link_valid_reg[link_up];
                end
                else if (!phase_b_reg)
                begin
                    ra_next          = walk_root;
                    walk_v_next      = b_reg;
                    step_next        = '0;
                    phase_b_next     = 1'b1;
                    link_raddr       = b_reg;
                    link_rvalid_next = link_valid_reg[b_reg];
                end
                else
                begin
                    rb_next    = walk_root;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if ((ra_reg != rb_reg) || closing)
                begin
                    // link root of b under root of a, bump degree of a
                    link_we                 = 1'b1;
                    link_waddr              = rb_reg;
                    link_valid_next[rb_reg] = 1'b1;
                    deg_we                  = 1'b1;
                    deg_waddr               = a_reg;
                    deg_wdata               = deg_a_reg + 2'd1;
                    deg_valid_next[a_reg]   = 1'b1;
                    taken_next              = taken_reg + 7'd1;
                    sum_next                = sum_sat;
                    accepted_next           = 1'b1;
                    // self loop raises its one vertex only once
                    state_next = (b_reg != a_reg) ? S_DEG_UPD_B : S_RESULT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end

            S_DEG_UPD_B:
            begin
                deg_we                = 1'b1;
                deg_waddr             = b_reg;
                deg_wdata             = deg_b_reg + 2'd1;
                deg_valid_next[b_reg] = 1'b1;
                state_next            = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.accepted    = accepted_reg;
                    out_data_next.edges_taken = taken_reg;
                    out_data_next.tour_length = sum_reg;
                    out_data_next.tour_done   = (taken_reg == vcount_reg);
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= VCOUNT_RESET;
            taken_reg      <= '0;
            sum_reg        <= '0;
            link_valid_reg <= '0;
            deg_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            vcount_reg     <= vcount_next;
            taken_reg      <= taken_next;
            sum_reg        <= sum_next;
            link_valid_reg <= link_valid_next;
            deg_valid_reg  <= deg_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        w_reg           <= w_next;
        deg_a_reg       <= deg_a_next;
        deg_b_reg       <= deg_b_next;
        walk_v_reg      <= walk_v_next;
        step_reg        <= step_next;
        phase_b_reg     <= phase_b_next;
        ra_reg          <= ra_next;
        rb_reg          <= rb_next;
        accepted_reg    <= accepted_next;
        link_rvalid_reg <= link_rvalid_next;
        deg_rvalid_reg  <= deg_rvalid_next;
        out_data_reg    <= out_data_next;
    end

    // ---------------- assertions ----------------
    // Outside of item accept the edge count only moves up by one.
    a_taken_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |=>
            (taken_reg == $past(taken_reg)) || (taken_reg == $past(taken_reg) + 7'd1))
        else $error("edge count jumped");

    // Root walk stays within its step bound.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> int'(step_reg) < MAX_VERTICES)
        else $error("root walk overran");

    // An accepted edge never pushes the count past the tour size.
    a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.accepted |->
            (result.data.edges_taken != '0) && (result.data.edges_taken <= vcount_reg))
        else $error("accepted edge with bad count");

    // Degree writes only happen after an accept decision in the same item.
    a_deg_write: assert property (@(posedge clk) disable iff (!rst_n)
        deg_we |-> accepted_next)
        else $error("degree written for rejected edge");
endmodule

@@ src/gtes_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gtes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
